// File: sv/bbea_pkg.sv
// Shared types and constants for the block bitmap extent allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package bbea_pkg;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    // Most extents one allocate may return, and the run counter width
    localparam int MAX_RESULTS = 16;
    localparam int RUN_W       = 5;

    // Field widths of the beats
    localparam int START_W = 5;
    localparam int END_W   = 6;
    localparam int COUNT_W = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_DECIDE,
        S_CLAIM,
        S_FREE,
        S_ACK
    } t_state;

    // One result beat
    typedef struct packed {
        logic [START_W-1:0] extent_start;
        logic [END_W-1:0]   extent_end;
        logic               last;
        logic               status;
    } t_result;

    // Control of the rotating bitmap
    typedef struct packed {
        logic step;     // rotate by one block
        logic wr_bit;   // value written back for the head block
    } t_map_ctl;

endpackage

`default_nettype wire

// File: sv/block_bitmap_extent_allocator.sv
// Top level of the first-fit block bitmap extent allocator.
// Depends on bbea_pkg, bbea_map_sr, bbea_out_reg and bbea_ctrl.
//
//   channel   direction   handshake                fields
//   input     in          i_in_valid / o_in_stall  cmd, block_count, free_start, free_end
//   output    out         o_out_valid / i_out_stall extent_start, extent_end, last, status
//
// The used-block map rotates through a shift register, one block per cycle.
// Allocate: a counting pass over every block, one decide state, then a claim pass
// over every block; no space skips the claim pass and sends a status beat. Free
// makes one pass over every block and echoes its extent; a zero request only acks.
// Reset (synchronous, active low) marks every block free.
// A stalled output holds the claim pass at the block that closes a run.
`default_nettype none

module block_bitmap_extent_allocator
    import bbea_pkg::*;
#(
    parameter int NUM_BLOCKS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire                 i_cmd,
    input  wire [COUNT_W-1:0]   i_block_count,
    input  wire [START_W-1:0]   i_free_start,
    input  wire [END_W-1:0]     i_free_end,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [START_W-1:0]  o_extent_start,
    output logic [END_W-1:0]    o_extent_end,
    output logic                o_last,
    output logic                o_status
);

    t_map_ctl map_ctl;
    logic     head;
    logic     out_free;
    logic     load;
    t_result  res;

    bbea_map_sr #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (map_ctl),
        .o_head  (head)
    );

    bbea_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_block_count (i_block_count),
        .i_free_start  (i_free_start),
        .i_free_end    (i_free_end),
        .i_head        (head),
        .o_map_ctl     (map_ctl),
        .i_out_free    (out_free),
        .o_load        (load),
        .o_res         (res)
    );

    bbea_out_reg u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_res          (res),
        .o_free         (out_free),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_extent_start (o_extent_start),
        .o_extent_end   (o_extent_end),
        .o_last         (o_last),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

// File: sv/bbea_map_sr.sv
// Rotating bitmap of used blocks, one block per cycle at the head when stepped.
// Depends on bbea_pkg.
`default_nettype none

module bbea_map_sr
    import bbea_pkg::*;
#(
    parameter int NUM_BLOCKS = 32
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire t_map_ctl i_ctl,
    output logic          o_head
);

    logic [NUM_BLOCKS-1:0] r_map;
    logic [NUM_BLOCKS-1:0] n_map;

    // Head block leaves at bit 0 and re-enters at the top
    always_comb begin
        n_map = r_map;
        if (i_ctl.step) begin
            n_map = {i_ctl.wr_bit, r_map[NUM_BLOCKS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else begin
            r_map <= n_map;
        end
    end

    assign o_head = r_map[0];

endmodule

`default_nettype wire

// File: sv/bbea_out_reg.sv
// Output register for result beats; holds a beat while the sink stalls.
// Depends on bbea_pkg.
`default_nettype none

module bbea_out_reg
    import bbea_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire t_result        i_res,
    output logic                o_free,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [START_W-1:0]  o_extent_start,
    output logic [END_W-1:0]    o_extent_end,
    output logic                o_last,
    output logic                o_status
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Slot is free when empty or when its beat leaves this cycle
    assign o_free  = !r_valid || !i_out_stall;
    assign n_valid = i_load || (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_extent_start = r_res.extent_start;
    assign o_extent_end   = r_res.extent_end;
    assign o_last         = r_res.last;
    assign o_status       = r_res.status;

endmodule

`default_nettype wire

// File: sv/bbea_ctrl.sv
// Command sequencer: counting pass, claim pass and free pass over the
// rotating bitmap, one block per cycle unless a stalled output holds the claim pass. Depends on bbea_pkg.
`default_nettype none

module bbea_ctrl
    import bbea_pkg::*;
#(
    parameter int NUM_BLOCKS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire                 i_cmd,
    input  wire [COUNT_W-1:0]   i_block_count,
    input  wire [START_W-1:0]   i_free_start,
    input  wire [END_W-1:0]     i_free_end,
    input  wire                 i_head,
    output t_map_ctl            o_map_ctl,
    input  wire                 i_out_free,
    output logic                o_load,
    output t_result             o_res
);

    localparam int PW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [PW-1:0] LAST_POS = PW'(NUM_BLOCKS - 1);

    t_state             r_state,      n_state;
    logic [PW-1:0]      r_pos,        n_pos;
    logic [COUNT_W-1:0] r_need,       n_need;
    logic [COUNT_W-1:0] r_want,       n_want;
    logic [CW-1:0]      r_free_cnt,   n_free_cnt;
    logic [RUN_W-1:0]   r_runs,       n_runs;
    logic               r_in_run,     n_in_run;
    logic               r_frag,       n_frag;
    logic [PW-1:0]      r_start,      n_start;
    logic [START_W-1:0] r_fs,         n_fs;
    logic [END_W-1:0]   r_fe,         n_fe;
    logic               r_ack_status, n_ack_status;
    logic               r_ack_echo,   n_ack_echo;

    logic               accept;
    logic               last_pos;
    logic [PW-1:0]      run_start;
    logic [PW:0]        pos_next;
    logic [XW-1:0]      pos_x;
    logic               in_range;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign last_pos = (r_pos == LAST_POS);
    assign run_start = r_in_run ? r_start : r_pos;
    assign pos_next = {1'b0, r_pos} + 1'b1;
    assign pos_x    = XW'(r_pos);
    // The position never reaches NUM_BLOCKS, so the end needs no clamp
    assign in_range = (pos_x >= XW'(r_fs)) && (pos_x < XW'(r_fe));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_need       <= n_need;
        r_want       <= n_want;
        r_free_cnt   <= n_free_cnt;
        r_runs       <= n_runs;
        r_in_run     <= n_in_run;
        r_frag       <= n_frag;
        r_start      <= n_start;
        r_fs         <= n_fs;
        r_fe         <= n_fe;
        r_ack_status <= n_ack_status;
        r_ack_echo   <= n_ack_echo;
    end

    // Next state and outputs
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_need       = r_need;
        n_want       = r_want;
        n_free_cnt   = r_free_cnt;
        n_runs       = r_runs;
        n_in_run     = r_in_run;
        n_frag       = r_frag;
        n_start      = r_start;
        n_fs         = r_fs;
        n_fe         = r_fe;
        n_ack_status = r_ack_status;
        n_ack_echo   = r_ack_echo;
        o_map_ctl    = '{step: 1'b0, wr_bit: i_head};
        o_load       = 1'b0;
        o_res        = '{extent_start: '0, extent_end: '0, last: 1'b1,
                         status: STATUS_OK};
        o_in_stall   = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos      = '0;
                    n_fs       = i_free_start;
                    n_fe       = i_free_end;
                    n_want     = i_block_count;
                    n_need     = i_block_count;
                    n_free_cnt = '0;
                    n_runs     = '0;
                    n_in_run   = 1'b0;
                    n_frag     = 1'b0;
                    n_ack_echo = 1'b0;
                    n_ack_status = STATUS_OK;
                    if (i_cmd == CMD_FREE) begin
                        n_state = S_FREE;
                    end else if (i_block_count == '0) begin
                        n_state = S_ACK;
                    end else begin
                        n_state = S_COUNT;
                    end
                end
            end

            // Count free blocks and the runs the request would span
            S_COUNT: begin
                o_map_ctl.step = 1'b1;
                if (!i_head) begin
                    n_free_cnt = r_free_cnt + 1'b1;
                    if (r_need != '0) begin
                        if (!r_in_run) begin
                            if (r_runs == RUN_W'(MAX_RESULTS)) begin
                                n_frag = 1'b1;
                            end else begin
                                n_runs = r_runs + 1'b1;
                            end
                        end
                        n_in_run = 1'b1;
                        n_need   = r_need - 1'b1;
                    end
                end else if (r_need != '0) begin
                    n_in_run = 1'b0;
                end
                n_pos = r_pos + 1'b1;
                if (last_pos) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_pos    = '0;
                n_need   = r_want;
                n_in_run = 1'b0;
                if (r_frag || (XW'(r_want) > XW'(r_free_cnt))) begin
                    n_ack_status = STATUS_NO_SPACE;
                    n_state      = S_ACK;
                end else begin
                    n_state = S_CLAIM;
                end
            end

            // Claim lowest free blocks; a beat leaves as each run closes
            S_CLAIM: begin
                if (r_need != '0 && !i_head) begin
                    o_map_ctl.wr_bit = 1'b1;
                    if (r_need == COUNT_W'(1)) begin
                        o_res.extent_start = START_W'(run_start);
                        o_res.extent_end   = END_W'(pos_next);
                        o_res.last         = 1'b1;
                        o_load             = i_out_free;
                        o_map_ctl.step     = i_out_free;
                    end else begin
                        o_map_ctl.step = 1'b1;
                    end
                    if (o_map_ctl.step) begin
                        n_need   = r_need - 1'b1;
                        n_in_run = 1'b1;
                        n_start  = run_start;
                    end
                end else if (r_need != '0 && r_in_run) begin
                    o_res.extent_start = START_W'(r_start);
                    o_res.extent_end   = END_W'({1'b0, r_pos});
                    o_res.last         = 1'b0;
                    o_load             = i_out_free;
                    o_map_ctl.step     = i_out_free;
                    if (i_out_free) begin
                        n_in_run = 1'b0;
                    end
                end else begin
                    o_map_ctl.step = 1'b1;
                end
                if (o_map_ctl.step) begin
                    n_pos = r_pos + 1'b1;
                    if (last_pos) begin
                        n_state = S_IDLE;
                    end
                end
            end

            // Clear the blocks of one extent
            S_FREE: begin
                o_map_ctl.step   = 1'b1;
                o_map_ctl.wr_bit = in_range ? 1'b0 : i_head;
                n_pos            = r_pos + 1'b1;
                if (last_pos) begin
                    n_ack_echo = 1'b1;
                    n_state    = S_ACK;
                end
            end

            // Single beat: free echo, zero request or no space
            S_ACK: begin
                if (r_ack_echo) begin
                    o_res.extent_start = r_fs;
                    o_res.extent_end   = r_fe;
                end
                o_res.status = r_ack_status;
                o_load       = i_out_free;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
